>>> design/fatc_pkg.sv
// ----------------------------------------------------------------------------
// fatc_pkg
// Shared types, codes and constants of the frame acknowledge throttle.
// ----------------------------------------------------------------------------
package fatc_pkg;

	// event kinds carried in tuser
	localparam logic [2:0] KIND_SENT      = 3'd0;
	localparam logic [2:0] KIND_ACKED     = 3'd1;
	localparam logic [2:0] KIND_WITHDRAWN = 3'd2;
	localparam logic [2:0] KIND_CLEAR     = 3'd3;
	localparam logic [2:0] KIND_RTT       = 3'd4;

	// configuration register indexes
	localparam logic REG_FRAME_RATE = 1'b0;
	localparam logic REG_RELEASE    = 1'b1;

	localparam logic [7:0] FRAME_RATE_RESET = 8'd60;
	localparam logic       RELEASE_RESET    = 1'b1;
	localparam logic [7:0] ENGAGE_RESET     = 8'd2;
	localparam logic [7:0] ENGAGE_MIN       = 8'd2;

	// floor(p / 1e6) = floor(floor(p / 64) * DIV_RECIP / 2^DIV_SHIFT), exact for p < 2^32
	localparam int          PRE_SHIFT = 6;
	localparam int          DIV_SHIFT = 40;
	localparam logic [26:0] DIV_RECIP = 27'd70368745;

	// external mode codes on the result port
	localparam logic [1:0] CODE_INACTIVE = 2'd0;
	localparam logic [1:0] CODE_ACTIVE   = 2'd1;
	localparam logic [1:0] CODE_LOWERING = 2'd2;

	typedef enum logic [2:0] {
		MODE_INACTIVE = 3'b001,
		MODE_ACTIVE   = 3'b010,
		MODE_LOWERING = 3'b100
	} mode_t;

	// one input event, kind apart
	typedef struct packed {
		logic [23:0] round_trip_us;
		logic [7:0]  acknowledge_rate;
		logic [7:0]  encode_rate;
		logic [9:0]  pending_frames;
	} item_t;

	// outcome of one event, from the decision logic to the top level
	typedef struct packed {
		logic       slots_valid;
		logic       slots_unlimited;
		logic [8:0] slot_budget;
		mode_t      next_mode;
		logic [7:0] next_engage;
	} step_res_t;

	function automatic logic [1:0] mode_code(input mode_t m);
		logic [1:0] c;
		c = CODE_INACTIVE;
		unique case (m)
			MODE_INACTIVE: c = CODE_INACTIVE;
			MODE_ACTIVE:   c = CODE_ACTIVE;
			MODE_LOWERING: c = CODE_LOWERING;
			default:       c = CODE_INACTIVE;
		endcase
		return c;
	endfunction

endpackage

>>> design/fatc_thresh.sv
// ----------------------------------------------------------------------------
// fatc_thresh
// Round-trip register and the two-stage pipeline that turns it into the
// engage threshold max(2, min(rtt * frame_rate / 1e6 + 2, frame_rate)).
// ----------------------------------------------------------------------------
module fatc_thresh (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rtt_load,
	input  logic [23:0] rtt_value,
	input  logic [7:0]  frame_rate,
	output logic [7:0]  cur_thresh
);
	import fatc_pkg::*;

	logic [23:0] last_rtt_q;
	logic [31:0] prod_s1;
	logic [12:0] quot_s2;
	logic [52:0] scaled;
	logic [13:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rtt_q <= '0;
		end else if (rtt_load) begin
			last_rtt_q <= rtt_value;
		end
	end

	// free-running: rtt times rate, then divide by one million via reciprocal
	assign scaled = {27'd0, prod_s1[31:PRE_SHIFT]} * {26'd0, DIV_RECIP};

	always_ff @(posedge clk) begin
		prod_s1 <= {8'd0, last_rtt_q} * {24'd0, frame_rate};
		quot_s2 <= scaled[DIV_SHIFT +: 13];
	end

	// clamp to the frame rate, then hold at least two
	always_comb begin
		sum = {1'b0, quot_s2} + 14'd2;
		if (sum > {6'd0, frame_rate}) begin
			cur_thresh = frame_rate;
		end else begin
			cur_thresh = sum[7:0];
		end
		if (cur_thresh < ENGAGE_MIN) begin
			cur_thresh = ENGAGE_MIN;
		end
	end

endmodule

>>> design/fatc_step.sv
// ----------------------------------------------------------------------------
// fatc_step
// Decision logic for one event: next mode, next threshold and slot budget.
// ----------------------------------------------------------------------------
module fatc_step (
	input  logic                  [2:0] kind,
	input  fatc_pkg::item_t             item,
	input  fatc_pkg::mode_t             mode,
	input  logic                  [7:0] engage,
	input  logic                  [7:0] cur_thresh,
	input  logic                        release_threshold,
	output fatc_pkg::step_res_t         res
);
	import fatc_pkg::*;

	logic [9:0] pend;
	logic [9:0] cur_ext;
	logic [9:0] ack_ext;
	logic [9:0] enc_ext;
	logic [9:0] sent_budget;
	logic [9:0] ack_budget;
	logic       lowered;

	assign pend    = item.pending_frames;
	assign cur_ext = {2'd0, cur_thresh};
	assign ack_ext = {2'd0, item.acknowledge_rate};
	assign enc_ext = {2'd0, item.encode_rate};
	assign lowered = cur_thresh < engage;

	// budget after a send allows one more frame in flight than after an ack
	assign sent_budget = (enc_ext > ack_ext + 10'd1) ? 10'd0 : ack_ext + 10'd2 - enc_ext;
	assign ack_budget  = (enc_ext > ack_ext) ? 10'd0 : ack_ext + 10'd1 - enc_ext;

	always_comb begin
		res.slots_valid     = 1'b0;
		res.slots_unlimited = 1'b0;
		res.slot_budget     = '0;
		res.next_mode       = mode;
		res.next_engage     = engage;
		unique case (kind) inside
			KIND_SENT, KIND_WITHDRAWN: begin
				unique case (mode)
					MODE_INACTIVE: begin
						res.next_engage = cur_thresh;
						if (pend >= cur_ext) begin
							res.next_mode   = MODE_ACTIVE;
							res.slots_valid = 1'b1;
						end
					end
					MODE_ACTIVE: begin
						// withdrawn acks only re-evaluate an idle throttle
						if (kind == KIND_SENT) begin
							res.slots_valid = 1'b1;
							if (lowered) begin
								res.next_mode = MODE_LOWERING;
							end else begin
								res.next_engage = cur_thresh;
								res.slot_budget = sent_budget[8:0];
							end
						end
					end
					default: ;
				endcase
			end
			KIND_ACKED: begin
				unique case (mode)
					MODE_ACTIVE: begin
						res.slots_valid = 1'b1;
						if (pend <= {9'd0, release_threshold}) begin
							res.next_mode       = MODE_INACTIVE;
							res.slots_unlimited = 1'b1;
						end else if (lowered) begin
							res.next_mode = MODE_LOWERING;
						end else begin
							res.next_engage = cur_thresh;
							res.slot_budget = ack_budget[8:0];
						end
					end
					MODE_LOWERING: begin
						if (pend < cur_ext) begin
							res.next_mode       = MODE_INACTIVE;
							res.slots_valid     = 1'b1;
							res.slots_unlimited = 1'b1;
						end else if (pend == cur_ext) begin
							res.next_mode   = MODE_ACTIVE;
							res.slots_valid = 1'b1;
							res.slot_budget = ack_budget[8:0];
						end
					end
					default: ;
				endcase
			end
			KIND_CLEAR: begin
				res.next_mode       = MODE_INACTIVE;
				res.slots_valid     = 1'b1;
				res.slots_unlimited = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

>>> design/frame_ack_throttle_controller.sv
// ----------------------------------------------------------------------------
// frame_ack_throttle_controller
// Three-mode encoder throttle driven by frame sent / acked / withdrawn / clear and round-trip events.
// ----------------------------------------------------------------------------
// Each event passes through the input register and then the result register, from
// which it leaves on the result stream; a stalled result stream holds both.
// Throughput: one event per cycle while the result stream is not stalled. A new
// round-trip event holds off input after its own accept, as does a frame rate
// write, while the threshold pipeline (multiply, reciprocal multiply) refills.
// After reset: mode inactive, threshold 2, round trip 0, frame rate 60, release 1; input held during fill.
// ----------------------------------------------------------------------------
module frame_ack_throttle_controller (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata,
	// event stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // pending_frames, encode_rate, acknowledge_rate, round_trip_us
	input  logic [2:0]  s_tuser,   // kind
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // slot_budget, mode_now
	output logic [1:0]  m_tuser    // slots_valid, slots_unlimited
);
	import fatc_pkg::*;

	// configuration
	logic [7:0] frame_rate_q;
	logic       release_q;

	// input stage
	logic       in_valid_s1;
	logic [2:0] kind_s1;
	item_t      item_s1;

	// throttle state
	mode_t      mode_q;
	logic [7:0] engage_q;

	// result stage
	logic       out_valid_s2;
	logic       out_slots_valid_s2;
	logic       out_unlimited_s2;
	logic [8:0] out_budget_s2;
	logic [1:0] out_mode_s2;

	// counts down while the threshold pipeline refills; input is held until zero
	logic [1:0] warm_cnt_q;

	logic       out_free;
	logic       adv_s1;
	logic       hold_in;
	logic       take_in;
	logic       rtt_load;
	logic       rate_write;
	logic [7:0] cur_thresh;
	step_res_t  res;

	assign out_free   = !out_valid_s2 || m_tready;
	assign adv_s1     = in_valid_s1 && out_free;
	assign rtt_load   = adv_s1 && (kind_s1 == KIND_RTT);
	assign rate_write = cfg_we && (cfg_index == REG_FRAME_RATE);

	// Hold input while a round-trip event sits in the input stage, so that the
	// event behind it never sees a stale threshold, and while the pipeline refills.
	assign hold_in  = (warm_cnt_q != 2'd0) || (in_valid_s1 && (kind_s1 == KIND_RTT));
	assign s_tready = (!in_valid_s1 || adv_s1) && !hold_in;
	assign take_in  = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rate_q <= FRAME_RATE_RESET;
			release_q    <= RELEASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FRAME_RATE: frame_rate_q <= cfg_wdata;
				REG_RELEASE:    release_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Restart the refill count on a new round trip or a new frame rate, drain otherwise.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_cnt_q <= 2'd2;
		end else if (rtt_load || rate_write) begin
			warm_cnt_q <= 2'd1;
		end else if (warm_cnt_q != 2'd0) begin
			warm_cnt_q <= warm_cnt_q - 2'd1;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (take_in) begin
			in_valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1 <= s_tuser;
			item_s1 <= s_tdata[49:0];
		end
	end

	fatc_thresh u_thresh (
		.clk        (clk),
		.arst_n     (arst_n),
		.rtt_load   (rtt_load),
		.rtt_value  (item_s1.round_trip_us),
		.frame_rate (frame_rate_q),
		.cur_thresh (cur_thresh)
	);

	fatc_step u_step (
		.kind              (kind_s1),
		.item              (item_s1),
		.mode              (mode_q),
		.engage            (engage_q),
		.cur_thresh        (cur_thresh),
		.release_threshold (release_q),
		.res               (res)
	);

	// Commit the mode and threshold as the event moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_INACTIVE;
			engage_q <= ENGAGE_RESET;
		end else if (adv_s1) begin
			mode_q   <= res.next_mode;
			engage_q <= res.next_engage;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_slots_valid_s2 <= res.slots_valid;
			out_unlimited_s2   <= res.slots_unlimited;
			out_budget_s2      <= res.slot_budget;
			out_mode_s2        <= mode_code(res.next_mode);
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {5'd0, out_mode_s2, out_budget_s2};
	assign m_tuser  = {out_unlimited_s2, out_slots_valid_s2};

endmodule
